### rtl/core/rrt_pkg.sv
// ----------------------------------------------------------------------------
// Range reservation table: shared package
// Field widths, result codes and the token that walks the row of cells.
// ----------------------------------------------------------------------------
`default_nettype none

package rrt_pkg;

    localparam int START_W  = 32;
    localparam int LEN_W    = 28;
    localparam int STATUS_W = 3;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_GRANTED  = 3'd0;
    localparam t_status ST_OVERLAP  = 3'd1;
    localparam t_status ST_FULL     = 3'd2;
    localparam t_status ST_NOADDR   = 3'd3;
    localparam t_status ST_RELEASED = 3'd4;
    localparam t_status ST_NOTFOUND = 3'd5;

    // The request token handed from one cell to the next.
    typedef struct packed {
        logic valid;   // token present at this cell boundary
        logic busy;    // an earlier live entry overlaps the request
        logic found;   // an earlier live entry matched the release start
    } t_token;

endpackage

`default_nettype wire

### rtl/core/rrt_if.sv
// ----------------------------------------------------------------------------
// Range reservation table: channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rrt_in_if
    import rrt_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               mode;
    logic [START_W-1:0] region_start;
    logic [LEN_W-1:0]   region_length;

    modport source (output valid, output mode, output region_start,
                    output region_length, input ready);
    modport sink   (input valid, input mode, input region_start,
                    input region_length, output ready);
endinterface

interface rrt_out_if
    import rrt_pkg::*;
();
    logic               valid;
    logic               ready;
    t_status            status;
    logic [START_W-1:0] granted_start;

    modport source (output valid, output status, output granted_start, input ready);
    modport sink   (input valid, input status, input granted_start, output ready);
endinterface

`default_nettype wire

### rtl/core/rrt_cell.sv
// ----------------------------------------------------------------------------
// Range reservation table: table cell
// Holds one table entry, tests the passing request token against it and,
// during a release, takes over its upper neighbour's entry to close a gap.
// ----------------------------------------------------------------------------
`default_nettype none

module rrt_cell
    import rrt_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CB    = 28,
    parameter int CNT_W = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_token             i_tok,
    output      t_token             o_tok,
    input  wire logic               i_mode,
    input  wire logic [START_W-1:0] i_req_start,
    input  wire logic [LEN_W-1:0]   i_req_len,
    input  wire logic [CNT_W-1:0]   i_cnt,
    input  wire logic               i_wr_en,
    input  wire logic [START_W-1:0] i_nb_start,
    input  wire logic [LEN_W-1:0]   i_nb_len,
    output      logic [START_W-1:0] o_start,
    output      logic [LEN_W-1:0]   o_len
);

    localparam int SW = ((CB > LEN_W) ? CB : LEN_W) + 1;

    logic [START_W-1:0] r_start, n_start;
    logic [LEN_W-1:0]   r_len, n_len;
    t_token             r_tok, n_tok;

    logic          live;
    logic          match;
    logic          ovl;
    logic          shift;
    logic [SW-1:0] a, s, e, t;

    always_comb begin
        a = SW'(i_req_start[CB-1:0]);
        s = SW'(i_req_len);
        e = SW'(r_start[CB-1:0]);
        t = SW'(r_len);
        // Both ends inclusive, so touching regions overlap.
        ovl   = ((e >= a) && (e <= a + s)) || ((a >= e) && (a <= e + t));
        live  = (CNT_W'(IDX) < i_cnt);
        match = (r_start == i_req_start);
        shift = i_tok.valid && i_mode && (i_tok.found || (live && match));

        n_tok.valid = i_tok.valid;
        n_tok.busy  = i_tok.busy  || (i_tok.valid && live && !i_mode && ovl);
        n_tok.found = i_tok.found || (i_tok.valid && live && i_mode && match);

        n_start = r_start;
        n_len   = r_len;
        if (i_wr_en && (i_cnt == CNT_W'(IDX))) begin
            n_start = i_req_start;
            n_len   = i_req_len;
        end else if (shift) begin
            n_start = i_nb_start;
            n_len   = i_nb_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_len   <= n_len;
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok   = r_tok;
    assign o_start = r_start;
    assign o_len   = r_len;

endmodule

`default_nettype wire

### rtl/core/range_reservation_table_core.sv
// ----------------------------------------------------------------------------
// Range reservation table: top level
// Table of reserved address regions kept in a row of cells; reserve
// requests are checked for overlap and appended, release requests remove
// the first matching entry and the entries above it move down.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Item contents
//  --------+-----------+------------------------------------------------
//  i_req   | in        | mode, region_start, region_length
//  o_rsp   | out       | status, granted_start
//
//  From acceptance, a launch register starts a token that walks the row of
//  cells one cell per cycle; its result is registered at the end of the row
//  and then committed to the output register.
//  One item is worked on at a time; i_req.ready is low while one is in flight.
//  A result waiting in the output register does not hold back acceptance,
//  but a finished item is only committed once that register is free.
//  Reset clears the entry count and the control state, and i_req.ready is
//  held low while it lasts; entry contents are not cleared, as only entries
//  below the count are ever looked at.
//
`default_nettype none

module range_reservation_table_core
    import rrt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 128,
    parameter int COMPARE_BITS  = 28
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rrt_in_if.sink     i_req,
    rrt_out_if.source  o_rsp
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    // Request held for the whole of its walk along the row.
    logic               r_mode;
    logic [START_W-1:0] r_start;
    logic [LEN_W-1:0]   r_len;

    logic               r_active, n_active;
    logic               r_launch, n_launch;
    logic               r_fin, n_fin;
    logic               r_fin_busy, r_fin_found;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    logic               r_out_valid, n_out_valid;
    t_status            r_out_status;
    logic [START_W-1:0] r_out_granted;

    t_token             tok [TABLE_ENTRIES+1];
    logic [START_W-1:0] ent_start [TABLE_ENTRIES];
    logic [LEN_W-1:0]   ent_len   [TABLE_ENTRIES];

    logic               accept;
    logic               commit;
    logic               wr_en;
    t_status            status;

    // No item is taken while reset is applied.
    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = i_rst_n && !r_active;

    // The token enters the first cell in the cycle after acceptance.
    assign tok[0] = '{valid: r_launch, busy: 1'b0, found: 1'b0};

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        logic [START_W-1:0] nb_start;
        logic [LEN_W-1:0]   nb_len;

        // The top cell has no upper neighbour; what it copies lies above
        // the count after the release and is never read.
        if (g == TABLE_ENTRIES - 1) begin : g_top
            assign nb_start = ent_start[g];
            assign nb_len   = ent_len[g];
        end else begin : g_mid
            assign nb_start = ent_start[g+1];
            assign nb_len   = ent_len[g+1];
        end

        rrt_cell #(
            .IDX   (g),
            .CB    (COMPARE_BITS),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_tok       (tok[g]),
            .o_tok       (tok[g+1]),
            .i_mode      (r_mode),
            .i_req_start (r_start),
            .i_req_len   (r_len),
            .i_cnt       (r_cnt),
            .i_wr_en     (wr_en),
            .i_nb_start  (nb_start),
            .i_nb_len    (nb_len),
            .o_start     (ent_start[g]),
            .o_len       (ent_len[g])
        );
    end

    // Result of the walk, decided once the token has left the last cell.
    always_comb begin
        if (r_mode) begin
            status = r_fin_found ? ST_RELEASED : ST_NOTFOUND;
        end else if (r_start == {START_W{1'b1}}) begin
            status = ST_NOADDR;
        end else if (r_fin_busy) begin
            status = ST_OVERLAP;
        end else if (r_cnt == CNT_W'(TABLE_ENTRIES)) begin
            status = ST_FULL;
        end else begin
            status = ST_GRANTED;
        end
    end

    // A finished item is committed when the output register can take it.
    assign commit = r_fin && (!r_out_valid || o_rsp.ready);
    assign wr_en  = commit && (status == ST_GRANTED);

    always_comb begin
        n_active    = r_active;
        n_launch    = accept;
        n_fin       = r_fin;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;

        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
        if (accept) begin
            n_active = 1'b1;
        end
        if (tok[TABLE_ENTRIES].valid) begin
            n_fin = 1'b1;
        end
        if (commit) begin
            n_fin       = 1'b0;
            n_active    = 1'b0;
            n_out_valid = 1'b1;
            if (status == ST_GRANTED) begin
                n_cnt = r_cnt + 1'b1;
            end else if (status == ST_RELEASED) begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= i_req.mode;
            r_start <= i_req.region_start;
            r_len   <= i_req.region_length;
        end
        if (tok[TABLE_ENTRIES].valid) begin
            r_fin_busy  <= tok[TABLE_ENTRIES].busy;
            r_fin_found <= tok[TABLE_ENTRIES].found;
        end
        if (commit) begin
            r_out_status  <= status;
            r_out_granted <= (status == ST_GRANTED) ? r_start : '0;
        end
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_launch    <= 1'b0;
            r_fin       <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_launch    <= n_launch;
            r_fin       <= n_fin;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.granted_start = r_out_granted;

endmodule

`default_nettype wire

### rtl/core/rrt_checker.sv
// ----------------------------------------------------------------------------
// Range reservation table: port checker
// Watches the top level's channels and flags behaviour the block must not show.
// ----------------------------------------------------------------------------
`default_nettype none

module rrt_checker
    import rrt_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               i_in_ready,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire t_status            i_status,
    input wire logic [START_W-1:0] i_granted_start
);

    // Only granted results carry an address.
    a_grant_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status != ST_GRANTED)) |-> (i_granted_start == '0))
        else $error("non-grant result carries an address");

    // One item at a time: no acceptance in the cycle after one.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("item accepted while another is in flight");

    // The walk along the row lies between acceptance and its result, so no result appears straight away.
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |-> ##1 !$rose(i_out_valid))
        else $error("result appeared too soon after acceptance");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_status) && $stable(i_granted_start)))
        else $error("stalled result changed");

endmodule

bind range_reservation_table_core rrt_checker u_rrt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_req.valid),
    .i_in_ready      (i_req.ready),
    .i_out_valid     (o_rsp.valid),
    .i_out_ready     (o_rsp.ready),
    .i_status        (o_rsp.status),
    .i_granted_start (o_rsp.granted_start)
);

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Range reservation table: self-checking bench
// Drives reserve and release requests through the request channel. Each
// accepted request is run through a behavioural copy of the region table
// kept in the bench, and the response channel is checked item by item,
// in order, against the outcomes that copy works out.
// ----------------------------------------------------------------------------

module tb_top;

    import rrt_pkg::*;

    localparam int TABLE_ENTRIES = 128;
    localparam int COMPARE_BITS  = 28;
    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 7;

    // The block walks its whole row of cells for every request.
    localparam int ITEM_LATENCY  = TABLE_ENTRIES + 3;
    localparam int SETTLE_CYCLES = 2 * ITEM_LATENCY;

    localparam int RANDOM_ITEMS  = 1100;
    localparam int STALL_AFTER   = 300;   // results seen before the long hold-off
    localparam int STALL_CYCLES  = 800;
    localparam int CYCLE_LIMIT   = 1_000_000;

    // Request kinds carried in the mode field.
    localparam logic OP_RESERVE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Only the low address bits take part in the overlap test.
    localparam logic [START_W:0]   CMP_MASK = (33'd1 << COMPARE_BITS) - 33'd1;
    localparam logic [START_W-1:0] LOW_MASK = CMP_MASK[START_W-1:0];

    typedef enum int {PH_FILL, PH_CHURN, PH_DRAIN} t_phase;

    typedef struct packed {
        t_status            status;
        logic [START_W-1:0] granted;
    } t_outcome;

    // ------------------------------------------------------------------------
    // Region table copy and response checker
    // ------------------------------------------------------------------------
    class rrt_scoreboard;
        logic [START_W-1:0] slot_start [TABLE_ENTRIES];
        logic [LEN_W-1:0]   slot_len   [TABLE_ENTRIES];
        int unsigned        live;
        int unsigned        peak;
        int unsigned        errors;
        int unsigned        checked;
        int unsigned        tally [8];
        t_outcome           awaited [$];

        function new();
            live    = 0;
            peak    = 0;
            errors  = 0;
            checked = 0;
            foreach (tally[i]) tally[i] = 0;
        endfunction

        // Inclusive ends on both sides, so touching regions meet. The sums
        // are one bit wider than the masked addresses and never wrap.
        function bit spans_meet(logic [START_W:0] a, logic [START_W:0] s,
                                logic [START_W:0] e, logic [START_W:0] t);
            if (e >= a && e <= a + s) return 1'b1;
            if (a >= e && a <= e + t) return 1'b1;
            return 1'b0;
        endfunction

        // Works out the outcome of one accepted request and updates the copy.
        function void note_request(logic mode, logic [START_W-1:0] start,
                                   logic [LEN_W-1:0] len);
            t_outcome         res;
            logic [START_W:0] a;
            logic [START_W:0] e;
            bit               busy;
            int               hit;
            res.status  = ST_NOTFOUND;
            res.granted = '0;
            if (mode == OP_RESERVE) begin
                if (start == '1) begin
                    res.status = ST_NOADDR;
                end else begin
                    a    = {1'b0, start} & CMP_MASK;
                    busy = 1'b0;
                    for (int i = 0; i < live; i++) begin
                        e = {1'b0, slot_start[i]} & CMP_MASK;
                        if (spans_meet(a, 33'(len), e, 33'(slot_len[i])))
                            busy = 1'b1;
                    end
                    if (busy) begin
                        res.status = ST_OVERLAP;
                    end else if (live >= TABLE_ENTRIES) begin
                        res.status = ST_FULL;
                    end else begin
                        slot_start[live] = start;
                        slot_len[live]   = len;
                        live++;
                        if (live > peak) peak = live;
                        res.status  = ST_GRANTED;
                        res.granted = start;
                    end
                end
            end else begin
                hit = -1;
                for (int i = 0; i < live; i++)
                    if (hit < 0 && slot_start[i] == start) hit = i;
                if (hit >= 0) begin
                    for (int j = hit; j + 1 < live; j++) begin
                        slot_start[j] = slot_start[j + 1];
                        slot_len[j]   = slot_len[j + 1];
                    end
                    live--;
                    res.status = ST_RELEASED;
                end
            end
            awaited.push_back(res);
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t ns: %s", $time, msg);
            errors++;
        endtask

        task check_result(t_status status, logic [START_W-1:0] granted);
            t_outcome want;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("response %0h/%08h with no request pending",
                                          status, granted));
            end else begin
                want = awaited.pop_front();
                tally[want.status]++;
                if (status !== want.status)
                    report_mismatch($sformatf("response %0d: status %0h, wanted %0h",
                                              checked, status, want.status));
                if (granted !== want.granted)
                    report_mismatch($sformatf("response %0d: start %08h, wanted %08h",
                                              checked, granted, want.granted));
                checked++;
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block itself
    // ------------------------------------------------------------------------
    logic i_clk;
    logic i_rst_n;

    rrt_in_if  req_ch ();
    rrt_out_if rsp_ch ();

    range_reservation_table_core #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COMPARE_BITS  (COMPARE_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    rrt_scoreboard sb;
    int unsigned   send_burst;
    int unsigned   take_burst;
    int unsigned   long_holds;
    int unsigned   cycle_count;

    // Watchdog: a correct run finishes far inside this figure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Idle cycles before the next item on one side. Now and then a burst of
    // items goes through back to back, with no idling at all.
    function automatic int unsigned draw_wait(inout int unsigned burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            burst = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    // Upper address bits from one word, compared bits from another.
    function automatic logic [START_W-1:0] splice(logic [START_W-1:0] upper,
                                                  logic [START_W-1:0] lower);
        return (upper & ~LOW_MASK) | (lower & LOW_MASK);
    endfunction

    // Mostly short regions, so that the table can fill up; outside fill
    // phases, now and then a length drawn over the whole field, which tends
    // to block much of the address space until it is released again.
    function automatic logic [LEN_W-1:0] pick_len(t_phase kind);
        if (kind != PH_FILL && $urandom_range(0, 49) == 0)
            return LEN_W'($urandom);
        if ($urandom_range(0, 19) == 0)
            return '0;
        return LEN_W'($urandom_range(0, 4095));
    endfunction

    // Builds one request. Fill phases are nearly all reserves, drain phases
    // mostly release live entries, churn phases mix the two. Some reserves
    // are aimed at a live entry: same start, touching either end, just
    // clear of its top end, or aliased through the uncompared upper bits.
    task automatic make_request(input t_phase kind, output logic mode,
                                output logic [START_W-1:0] start,
                                output logic [LEN_W-1:0] len);
        int unsigned        share;
        int unsigned        k;
        logic [START_W-1:0] anchor;
        logic [START_W-1:0] span;
        case (kind)
            PH_FILL:  share = 95;
            PH_CHURN: share = 55;
            default:  share = 15;
        endcase
        len   = pick_len(kind);
        start = $urandom;
        if ($urandom_range(0, 99) < share) begin
            mode = OP_RESERVE;
            if (sb.live > 0 && $urandom_range(0, 4) == 0) begin
                k      = $urandom_range(0, sb.live - 1);
                anchor = sb.slot_start[k];
                span   = START_W'(sb.slot_len[k]);
                case ($urandom_range(0, 4))
                    0: start = anchor;
                    1: start = splice(start, anchor + span);
                    2: begin
                        len   = LEN_W'($urandom_range(0, 255));
                        start = splice(start, anchor - START_W'(len));
                    end
                    3: start = splice(start, anchor + span + 1);
                    default: start = splice(~anchor, anchor);
                endcase
            end else if ($urandom_range(0, 49) == 0) begin
                start = '1;
            end
        end else begin
            mode = OP_RELEASE;
            if (sb.live > 0 && $urandom_range(0, 9) < 8) begin
                k     = $urandom_range(0, sb.live - 1);
                start = sb.slot_start[k];
                // Same compared bits, other upper bits: must not be found.
                if ($urandom_range(0, 9) == 0) start = splice(~start, start);
            end else if ($urandom_range(0, 9) == 0) begin
                start = '1;
            end
        end
    endtask

    // Offers one item and returns at the edge where it is taken. The valid
    // line is only lowered when idle cycles come first, so it is never
    // dropped and raised again within one time step.
    task automatic send_request(logic mode, logic [START_W-1:0] start,
                                logic [LEN_W-1:0] len);
        int unsigned gap;
        gap = draw_wait(send_burst);
        if (gap > 0) begin
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_ch.valid         <= 1'b1;
        req_ch.mode          <= mode;
        req_ch.region_start  <= start;
        req_ch.region_length <= len;
        do @(posedge i_clk); while (!(req_ch.valid && req_ch.ready));
        // Noted here rather than in a separate monitor, so that the next
        // request is always built from an up-to-date copy of the table.
        sb.note_request(mode, start, len);
    endtask

    // ------------------------------------------------------------------------
    // Response side
    // ------------------------------------------------------------------------
    // Ready is held back for a random number of cycles before each item.
    // Once, after a few hundred responses, it stays low for a long stretch
    // while the sender carries on: the output register fills, the finished
    // item behind it cannot commit and the request channel stalls.
    initial begin : response_side
        int unsigned w;
        int unsigned held;
        bit          held_once;
        held_once = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (!held_once && sb.checked >= STALL_AFTER) begin
                held_once = 1'b1;
                long_holds++;
                @(negedge i_clk);
                rsp_ch.ready <= 1'b0;
                held = 0;
                while (held < STALL_CYCLES) begin
                    @(negedge i_clk);
                    held++;
                end
            end
            w = draw_wait(take_burst);
            if (w > 0) begin
                @(negedge i_clk);
                rsp_ch.ready <= 1'b0;
                repeat (w - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(rsp_ch.valid && rsp_ch.ready));
            sb.check_result(rsp_ch.status, rsp_ch.granted_start);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_sequence
        logic               mode;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
        int unsigned        sent;
        int unsigned        n;
        int unsigned        round;
        int unsigned        phase_len;
        t_phase             kind;

        // Every input is known from time zero.
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.mode          = OP_RESERVE;
        req_ch.region_start  = '0;
        req_ch.region_length = '0;
        rsp_ch.ready         = 1'b0;
        send_burst           = 0;
        take_burst           = 0;
        long_holds           = 0;
        cycle_count          = 0;
        sb                   = new();

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening. The table starts empty, so the first reserve is
        // granted and an identical second one is refused as an overlap.
        send_request(OP_RESERVE, 32'h0000_0000, 28'h000_0000);
        send_request(OP_RESERVE, 32'h0000_0000, 28'h000_0000);
        // An all-ones start means no address on a reserve; a release simply
        // searches for it and finds nothing.
        send_request(OP_RESERVE, 32'hFFFF_FFFF, 28'h000_0005);
        send_request(OP_RELEASE, 32'hFFFF_FFFF, 28'hFFF_FFFF);
        // Longest region at the very top of the compared space.
        send_request(OP_RESERVE, 32'hFFFF_FFFE, 28'hFFF_FFFF);
        send_request(OP_RESERVE, 32'h0000_0001, 28'h000_0010);
        // Touching the top end of the region just granted.
        send_request(OP_RESERVE, 32'h0000_0011, 28'h000_0003);
        send_request(OP_RESERVE, 32'h0000_0020, 28'h000_0000);
        // Touching from below: the new region ends where an entry begins.
        send_request(OP_RESERVE, 32'h0000_0018, 28'h000_0008);
        // Same compared bits, different upper bits: still an overlap, and a
        // release by that full address does not match.
        send_request(OP_RESERVE, 32'h1000_0020, 28'h000_0000);
        send_request(OP_RELEASE, 32'h1000_0020, 28'h000_0000);
        send_request(OP_RESERVE, 32'h0000_0012, 28'h000_0005);
        send_request(OP_RELEASE, 32'h0000_0020, 28'h000_0000);
        send_request(OP_RELEASE, 32'h0000_0020, 28'h000_0000);
        send_request(OP_RESERVE, 32'hA000_0100, 28'hFFF_FFFF);
        send_request(OP_RELEASE, 32'hFFFF_FFFE, 28'h000_0000);
        send_request(OP_RESERVE, 32'hAAAA_A100, 28'hAAA_AAAA);
        send_request(OP_RESERVE, 32'h5555_5000, 28'h555_5555);
        // Clear out what is left so the random part starts from empty.
        send_request(OP_RELEASE, 32'hAAAA_A100, 28'h000_0000);
        send_request(OP_RELEASE, 32'h5555_5000, 28'h000_0000);
        send_request(OP_RELEASE, 32'h0000_0001, 28'h000_0000);
        send_request(OP_RELEASE, 32'h0000_0012, 28'h000_0000);
        send_request(OP_RELEASE, 32'h0000_0000, 28'h000_0000);

        // Random part in phases: fill the table past full, churn it, then
        // drain it, and round again.
        sent  = 0;
        round = 0;
        while (sent < RANDOM_ITEMS) begin
            kind      = t_phase'(round % 3);
            phase_len = (kind == PH_CHURN) ? 150 : 200;
            for (n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
                make_request(kind, mode, start, len);
                send_request(mode, start, len);
                sent++;
            end
            round++;
        end

        @(negedge i_clk);
        req_ch.valid <= 1'b0;

        // Wait for the last response, then a little longer in case anything
        // stray comes out of the block.
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("run covered %0d requests: %0d granted, %0d overlapping, %0d table full,",
                 sb.checked, sb.tally[ST_GRANTED], sb.tally[ST_OVERLAP],
                 sb.tally[ST_FULL]);
        $display("%0d without address, %0d released, %0d unknown; peak %0d of %0d slots, %0d long hold",
                 sb.tally[ST_NOADDR], sb.tally[ST_RELEASED], sb.tally[ST_NOTFOUND],
                 sb.peak, TABLE_ENTRIES, long_holds);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
